// ===== design/mlfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;
    localparam int LEVELS = 3;
    localparam logic [1:0] LOWEST_LEVEL = 2'(LEVELS - 1);

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_WAKE  = 3'd1;
    localparam logic [2:0] MODE_YIELD = 3'd2;
    localparam logic [2:0] MODE_BLOCK = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    localparam logic [2:0] CFG_Q0       = 3'd0;
    localparam logic [2:0] CFG_Q1       = 3'd1;
    localparam logic [2:0] CFG_Q2       = 3'd2;
    localparam logic [2:0] CFG_IDLE_ID  = 3'd3;
    localparam logic [2:0] CFG_IDLE_EN  = 3'd4;

    localparam logic [1:0] ST_UNUSED   = 2'd0;
    localparam logic [1:0] ST_RUNNABLE = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;
    localparam logic [1:0] ST_SLEEPING = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch word and decode
        logic pre_op;    // apply add/wake/yield/block update, tick count and push
        logic sched;     // pop and choose next process
        logic emit;      // load output register
    } t_cmd;

    typedef struct packed {
        logic need_sched;
    } t_stat;
endpackage
`default_nettype wire

// ===== design/mlfq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mlfq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_fire,
    input  wire logic           i_out_free,
    input  wire mlfq_pkg::t_stat i_stat,
    output mlfq_pkg::t_cmd      o_cmd,
    output logic                o_busy
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OP   = 2'd1;
    localparam logic [1:0] S_SCH  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state, n_state;

    // sequence one event through op, schedule and emit
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_fire;
                if (i_in_fire) n_state = S_OP;
            end
            S_OP: begin
                o_cmd.pre_op = 1'b1;
                n_state = S_SCH;
            end
            S_SCH: begin
                o_cmd.sched = i_stat.need_sched;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule
`default_nettype wire

// ===== design/mlfq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mlfq_dp #(
    parameter int MAX_PROCESSES = 16,
    parameter int QUANTUM_BITS  = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mlfq_pkg::t_cmd  i_cmd,
    output mlfq_pkg::t_stat      o_stat,
    input  wire logic [2:0]      i_mode,
    input  wire logic [3:0]      i_pid,
    input  wire logic            i_cfg_fire,
    input  wire logic [2:0]      i_cfg_index,
    input  wire logic [7:0]      i_cfg_data,
    output logic [12:0]          o_result
);
    localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam logic [QUANTUM_BITS-1:0] QMAX = '1;

    logic [7:0] r_quant [3];
    logic [3:0] r_idle_id;
    logic       r_idle_en;

    logic [PW-1:0] r_head [3];
    logic [PW-1:0] r_tail [3];
    logic [CW-1:0] r_count [3];
    logic [PW-1:0] r_link [MAX_PROCESSES];
    logic [1:0]    r_level [MAX_PROCESSES];
    logic [1:0]    r_status [MAX_PROCESSES];
    logic          r_queued [MAX_PROCESSES];
    logic [PW-1:0] r_cur;
    logic          r_cur_v;
    logic [QUANTUM_BITS-1:0] r_slice;

    logic [2:0] r_mode;
    logic [3:0] r_pid;
    logic       r_need, r_ign;
    logic [PW-1:0] r_prev;
    logic       r_prev_v, r_sw;

    logic idle_ex, pid_rng, cur_idle, pid_idle;
    logic [PW-1:0] pidx, idle_idx;

    // idle ids beyond the process range mean no idle process
    assign idle_ex  = r_idle_en && ({28'd0, r_idle_id} < 32'(MAX_PROCESSES));
    assign pid_rng  = {28'd0, r_pid} < 32'(MAX_PROCESSES);
    assign pidx     = PW'(r_pid);
    assign idle_idx = PW'(r_idle_id);
    assign cur_idle = idle_ex && ({{(32-PW){1'b0}}, r_cur} == {28'd0, r_idle_id});
    assign pid_idle = idle_ex && (r_idle_id == r_pid);

    function automatic logic [QUANTUM_BITS-1:0] clampq(input logic [7:0] q);
        logic [QUANTUM_BITS-1:0] res;
        if (QUANTUM_BITS >= 8) res = QUANTUM_BITS'(q);
        else if ((q >> QUANTUM_BITS) != 8'd0) res = QMAX;
        else res = QUANTUM_BITS'(q);
        return res;
    endfunction

    // pre-op push target
    logic          push_en;
    logic [PW-1:0] push_id;
    logic [1:0]    push_lvl;
    logic [1:0]    lvl_inc;
    logic          any_q;
    logic          wake_ign;
    logic          tick_drop;

    assign any_q = (r_count[0] != '0) || (r_count[1] != '0) || (r_count[2] != '0);
    assign lvl_inc = (r_level[r_cur] < mlfq_pkg::LOWEST_LEVEL) ? r_level[r_cur] + 2'd1
                                                               : r_level[r_cur];
    assign wake_ign = !pid_rng || pid_idle || r_queued[pidx] || (r_cur_v && r_cur == pidx);
    assign tick_drop = r_cur_v && !cur_idle &&
                       (r_status[r_cur] == mlfq_pkg::ST_RUNNING) &&
                       (r_slice <= QUANTUM_BITS'(1));

    // choose which process the event pushes
    always_comb begin
        push_en = 1'b0; push_id = pidx; push_lvl = r_level[pidx];
        case (r_mode)
            mlfq_pkg::MODE_ADD: begin
                if (pid_rng) begin
                    push_en = 1'b1; push_lvl = 2'd0;
                end
            end
            mlfq_pkg::MODE_WAKE: begin
                if (!wake_ign) push_en = 1'b1;
            end
            mlfq_pkg::MODE_YIELD: begin
                if (r_cur_v && !cur_idle) begin
                    push_en = 1'b1; push_id = r_cur; push_lvl = r_level[r_cur];
                end
            end
            mlfq_pkg::MODE_TICK: begin
                if (tick_drop) begin
                    push_en = 1'b1; push_id = r_cur; push_lvl = lvl_inc;
                end
            end
            default: ;
        endcase
    end

    // scheduler pick
    logic          pick_q, pick_v;
    logic [1:0]    pick_lvl;
    logic [PW-1:0] pick_id;
    always_comb begin
        pick_q = 1'b1; pick_lvl = 2'd0;
        if (r_count[0] != '0) pick_lvl = 2'd0;
        else if (r_count[1] != '0) pick_lvl = 2'd1;
        else if (r_count[2] != '0) pick_lvl = 2'd2;
        else pick_q = 1'b0;
        pick_id = pick_q ? r_head[pick_lvl] : idle_idx;
        pick_v  = pick_q || idle_ex;
    end

    logic pick_idle;
    assign pick_idle = idle_ex && ({{(32-PW){1'b0}}, pick_id} == {28'd0, r_idle_id});

    assign o_stat.need_sched = r_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant[0] <= 8'd5; r_quant[1] <= 8'd10; r_quant[2] <= 8'd20;
            r_idle_id <= '0; r_idle_en <= 1'b0;
            for (int l = 0; l < 3; l++) begin
                r_head[l] <= '0; r_tail[l] <= '0; r_count[l] <= '0;
            end
            for (int p = 0; p < MAX_PROCESSES; p++) begin
                r_level[p] <= '0; r_status[p] <= mlfq_pkg::ST_UNUSED;
                r_queued[p] <= 1'b0;
            end
            r_cur <= '0; r_cur_v <= 1'b0; r_slice <= '0;
            r_need <= 1'b0; r_ign <= 1'b0; r_sw <= 1'b0;
            r_mode <= '0; r_pid <= '0; r_prev <= '0; r_prev_v <= 1'b0;
            o_result <= '0;
        end else begin
            // hold configuration writes
            if (i_cfg_fire) begin
                case (i_cfg_index)
                    mlfq_pkg::CFG_Q0:      r_quant[0] <= i_cfg_data;
                    mlfq_pkg::CFG_Q1:      r_quant[1] <= i_cfg_data;
                    mlfq_pkg::CFG_Q2:      r_quant[2] <= i_cfg_data;
                    mlfq_pkg::CFG_IDLE_ID: r_idle_id  <= i_cfg_data[3:0];
                    mlfq_pkg::CFG_IDLE_EN: r_idle_en  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // latch the word
            if (i_cmd.capture) begin
                r_mode <= i_mode; r_pid <= i_pid;
                r_prev <= r_cur; r_prev_v <= r_cur_v;
                r_need <= 1'b0; r_ign <= 1'b0; r_sw <= 1'b0;
            end
            // apply the event itself, including any push
            if (i_cmd.pre_op) begin
                case (r_mode)
                    mlfq_pkg::MODE_ADD: if (pid_rng) begin
                        r_status[pidx] <= mlfq_pkg::ST_RUNNABLE;
                        r_level[pidx] <= 2'd0;
                        // the idle process always runs on the lowest-level quantum
                        if (r_cur_v && r_cur == pidx)
                            r_slice <= clampq(r_quant[pid_idle ? mlfq_pkg::LOWEST_LEVEL
                                                               : 2'd0]);
                    end
                    mlfq_pkg::MODE_WAKE: begin
                        if (wake_ign) r_ign <= 1'b1;
                        else r_status[pidx] <= mlfq_pkg::ST_RUNNABLE;
                    end
                    mlfq_pkg::MODE_YIELD: begin
                        if (r_cur_v && !cur_idle)
                            r_status[r_cur] <= mlfq_pkg::ST_RUNNABLE;
                        r_need <= 1'b1;
                    end
                    mlfq_pkg::MODE_BLOCK: begin
                        if (r_cur_v && !cur_idle)
                            r_status[r_cur] <= mlfq_pkg::ST_SLEEPING;
                        r_need <= 1'b1;
                    end
                    mlfq_pkg::MODE_TICK: begin
                        if (!r_cur_v) r_need <= 1'b1;
                        else if (cur_idle) r_need <= any_q;
                        else if (r_status[r_cur] != mlfq_pkg::ST_RUNNING) r_need <= 1'b1;
                        else if (tick_drop) begin
                            r_slice <= '0;
                            r_level[r_cur] <= lvl_inc;
                            r_status[r_cur] <= mlfq_pkg::ST_RUNNABLE;
                            r_need <= 1'b1;
                        end else r_slice <= r_slice - QUANTUM_BITS'(1);
                    end
                    default: ;
                endcase
                if (push_en && !r_queued[push_id]) begin
                    if (r_count[push_lvl] != '0) r_link[r_tail[push_lvl]] <= push_id;
                    else r_head[push_lvl] <= push_id;
                    r_tail[push_lvl] <= push_id;
                    r_count[push_lvl] <= r_count[push_lvl] + CW'(1);
                    r_queued[push_id] <= 1'b1;
                end
            end
            // pop the winner and reload its slice
            if (i_cmd.sched) begin
                if (pick_q) begin
                    if (r_count[pick_lvl] > CW'(1)) r_head[pick_lvl] <= r_link[pick_id];
                    r_count[pick_lvl] <= r_count[pick_lvl] - CW'(1);
                    r_queued[pick_id] <= 1'b0;
                end
                if (pick_v) begin
                    r_cur <= pick_id; r_cur_v <= 1'b1;
                    r_status[pick_id] <= mlfq_pkg::ST_RUNNING;
                    r_slice <= clampq(r_quant[pick_idle ? mlfq_pkg::LOWEST_LEVEL
                                                        : r_level[pick_id]]);
                    r_sw <= !r_cur_v || (r_cur != pick_id);
                end else begin
                    r_cur <= '0; r_cur_v <= 1'b0; r_sw <= 1'b0;
                end
            end
            // load result word
            if (i_cmd.emit) begin
                o_result <= {r_ign, r_prev_v,
                             r_prev_v ? 4'(r_prev) : 4'd0,
                             r_sw, r_cur_v && cur_idle, r_cur_v,
                             r_cur_v ? 4'(r_cur) : 4'd0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/mlfq_process_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Three-level feedback-queue process scheduler.
// Slave stream (s_axis_*) takes one event word: mode and process id.
// Master stream (m_axis_*) returns one result word per event: running
// process, previous process, switch and wake-rejected flags.
// Configuration channel (i_cfg_*) writes quanta and idle-process settings;
// write only while no event is in flight.
// Each event runs through a four-state sequencer: capture, event update,
// schedule, emit. The event passes the update and schedule states before
// its result is loaded into the result register, and the next event is
// taken only once the result is loaded, so events do not overlap.
// The result register holds its word until the receiver takes it; a stalled
// receiver holds the scheduler in its emit state, but a new event may be
// accepted while the previous result waits.
// Synchronous active-low reset empties every queue, clears the current
// process and restores the default quanta.
module mlfq_process_scheduler_unit #(
    parameter int MAX_PROCESSES = 16,
    parameter int QUANTUM_BITS  = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [2:0] mode, [6:3] process_id
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [3:0] running_id, [4] running_valid, [5] running_is_idle, [6] switched,
    // [10:7] previous_id, [11] previous_valid, [12] request_ignored
    output logic [15:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    mlfq_pkg::t_cmd  cmd;
    mlfq_pkg::t_stat stat;
    logic busy, in_fire, out_free;
    logic [12:0] result;
    logic r_ovalid;

    assign s_axis_tready = !busy;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire),
        .i_out_free(out_free), .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    mlfq_dp #(.MAX_PROCESSES(MAX_PROCESSES), .QUANTUM_BITS(QUANTUM_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_mode(s_axis_tdata[2:0]), .i_pid(s_axis_tdata[6:3]),
        .i_cfg_fire(i_cfg_valid), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_result(result)
    );

    // hold output word valid until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (cmd.emit) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, result};
endmodule
`default_nettype wire
